/* sv/fte_pkg.sv */
// ---------------------------------------------------------------------------
// fte_pkg
// Shared types, constants and the sine table generator for the Fourier
// trajectory evaluator.
// ---------------------------------------------------------------------------
package fte_pkg;

  // default sizes
  localparam int HARMONICS_DEF       = 8;
  localparam int JOINTS_DEF          = 12;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // reset value of position_scale (period over four pi, Q16.16)
  localparam logic [31:0] POS_SCALE_RESET = 32'd5215;

  // request codes
  localparam logic [1:0] REQ_WRITE_COEF  = 2'd0;
  localparam logic [1:0] REQ_WRITE_JOINT = 2'd1;
  localparam logic [1:0] REQ_EVALUATE    = 2'd2;

  // accumulator widths, sized for up to sixteen harmonics
  localparam int POS_W = 56;
  localparam int VEL_W = 40;

  // scaled position term and its long division by the harmonic number
  localparam int DIV_W     = 48;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;

  // sine table generator constants
  localparam longint unsigned Q30_ONE    = 64'd1073741824;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  // request payload
  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         joint_sel;
    logic [2:0]         harmonic_sel;
    logic signed [31:0] sine_amplitude;
    logic signed [31:0] cosine_amplitude;
    logic [15:0]        phase_offset;
    logic signed [31:0] base_position;
    logic [31:0]        time_fraction;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [3:0]         joint_index;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               saturated;
    logic               last;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WR_COEF,
    OP_WR_JOINT,
    OP_START,
    OP_JOINT_INIT,
    OP_RD_SIN,
    OP_RD_COS,
    OP_MUL_SA,
    OP_MUL_CB,
    OP_MUL_CA,
    OP_MUL_SB,
    OP_MUL_MLO,
    OP_MUL_MHI,
    OP_SCALE,
    OP_DIV_STEP,
    OP_ACCUM
  } dp_op_t;

  // command from controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [4:0] joint;
    logic [4:0] harm;
    logic       last;
  } dp_cmd_t;

  // one sine table entry in Q1.16, quadrant folded odd series
  function automatic logic signed [17:0] sine_entry(input int unsigned idx,
                                                    input int unsigned bits);
    longint unsigned p;
    longint unsigned u;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned q;
    logic            neg;
    logic signed [17:0] v;
    p = idx;
    p = (p << (32 - bits)) & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (p >= 64'h8000_0000) begin
      neg = 1'b1;
      p = p - 64'h8000_0000;
    end
    u = (p > 64'h4000_0000) ? (64'h8000_0000 - p) : p;
    theta = (u * TWO_PI_Q30) >> 32;
    t2 = (theta * theta) >> 30;
    r = Q30_ONE - ((t2 * Q30_ONE) >> 30) / 64'd110;
    r = Q30_ONE - ((t2 * r) >> 30) / 64'd72;
    r = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
    r = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
    r = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
    s = (theta * r) >> 30;
    q = (s + 64'd8192) >> 14;
    v = 18'(q);
    return neg ? -v : v;
  endfunction

endpackage

/* sv/fte_sine_rom.sv */
// ---------------------------------------------------------------------------
// fte_sine_rom
// Full-wave sine table, Q1.16, with a registered read port.
// ---------------------------------------------------------------------------
module fte_sine_rom #(
  parameter int SINE_TABLE_BITS = fte_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS-1:0] addr,
  output logic signed [17:0]         q
);

  localparam int DEPTH = 1 << SINE_TABLE_BITS;

  logic signed [17:0] rom [DEPTH];

  // table contents fixed at elaboration
  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    assign rom[i] = fte_pkg::sine_entry(i, SINE_TABLE_BITS);
  end

  // registered read
  always_ff @(posedge clk) begin
    q <= rom[addr];
  end

endmodule

/* sv/fte_datapath.sv */
// ---------------------------------------------------------------------------
// fte_datapath
// Coefficient stores, phase accumulator, shared multiplier, divider by the
// harmonic number, accumulators and the output register.
// ---------------------------------------------------------------------------
module fte_datapath #(
  parameter int HARMONICS       = fte_pkg::HARMONICS_DEF,
  parameter int JOINTS          = fte_pkg::JOINTS_DEF,
  parameter int SINE_TABLE_BITS = fte_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fte_pkg::dp_cmd_t   cmd,
  input  fte_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output fte_pkg::out_item_t out_data,
  output logic               out_busy
);

  localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int DEPTH = HARMONICS * JOINTS;
  localparam int CAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(HARMONICS + 1);
  localparam int B     = SINE_TABLE_BITS;
  localparam logic [B-1:0] QUARTER = {2'b01, {(B-2){1'b0}}};
  localparam int PW    = fte_pkg::POS_W;
  localparam int VW    = fte_pkg::VEL_W;
  localparam int DW    = fte_pkg::DIV_W;

  // stores
  logic signed [31:0] sine_mem [DEPTH];
  logic signed [31:0] cos_mem  [DEPTH];
  logic [15:0]        phase_mem [JOINTS];
  logic signed [31:0] base_mem  [JOINTS];

  logic [31:0]        position_scale;
  logic [31:0]        time_q;
  logic [31:0]        acc;
  logic [CAW-1:0]     caddr;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [17:0] s_q;
  logic signed [17:0] c_q;
  logic signed [50:0] prod;
  logic signed [50:0] t1;
  logic signed [50:0] t2;
  logic [32:0]        x_mag;
  logic               x_neg;
  logic [32:0]        v_mag;
  logic               v_neg;
  logic [31:0]        lo_part;
  logic [DW-1:0]      dq;
  logic [KW-1:0]      rem;
  logic signed [PW-1:0] pos;
  logic signed [VW-1:0] vel;

  logic                  wr_coef_ok;
  logic                  wr_joint_ok;
  logic [CAW-1:0]        wr_addr;
  logic [JW-1:0]         wr_joint;
  logic [JW-1:0]         jidx;
  logic [KW-1:0]         kval;
  logic [B-1:0]          sin_idx;
  logic [B-1:0]          rom_addr;
  logic signed [17:0]    rom_q;
  logic signed [17:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic [DW-1:0]         dq_next;
  logic [KW-1:0]         rem_next;
  logic                  pos_sat;
  logic                  vel_sat;

  // rounding of a Q32 product to Q16, magnitude half up
  function automatic logic [32:0] round_mag(input logic signed [50:0] v);
    logic [51:0] m;
    m = {1'b0, (v[50] ? -v : v)} + 52'd32768;
    return m[48:16];
  endfunction

  assign jidx     = JW'(cmd.joint);
  assign kval     = KW'(cmd.harm);
  assign wr_joint = JW'(in_data.joint_sel);
  assign wr_addr  = CAW'(int'(in_data.harmonic_sel) * JOINTS + int'(in_data.joint_sel));
  assign wr_coef_ok  = (cmd.op == fte_pkg::OP_WR_COEF) &&
                       (int'(in_data.joint_sel) < JOINTS) &&
                       (int'(in_data.harmonic_sel) < HARMONICS);
  assign wr_joint_ok = (cmd.op == fte_pkg::OP_WR_JOINT) &&
                       (int'(in_data.joint_sel) < JOINTS);

  // coefficient memories
  always_ff @(posedge clk) begin
    if (wr_coef_ok) begin
      sine_mem[wr_addr] <= in_data.sine_amplitude;
      cos_mem[wr_addr]  <= in_data.cosine_amplitude;
    end
    if (cmd.op == fte_pkg::OP_RD_SIN) begin
      a_q <= sine_mem[caddr];
      b_q <= cos_mem[caddr];
    end
  end

  // joint phase store
  always_ff @(posedge clk) begin
    if (wr_joint_ok) begin
      phase_mem[wr_joint] <= in_data.phase_offset;
    end
  end

  // joint base store, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        base_mem[i] <= '0;
      end
    end else if (wr_joint_ok) begin
      base_mem[wr_joint] <= in_data.base_position;
    end
  end

  // position scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      position_scale <= fte_pkg::POS_SCALE_RESET;
    end else if (cfg_we) begin
      position_scale <= cfg_data;
    end
  end

  // sine table lookup, cosine a quarter turn on
  assign sin_idx  = acc[31 -: B];
  assign rom_addr = (cmd.op == fte_pkg::OP_RD_COS) ? (sin_idx + QUARTER) : sin_idx;

  fte_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .q   (rom_q)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      fte_pkg::OP_MUL_SA: begin
        mul_a = s_q;
        mul_b = {a_q[31], a_q};
      end
      fte_pkg::OP_MUL_CB: begin
        mul_a = c_q;
        mul_b = {b_q[31], b_q};
      end
      fte_pkg::OP_MUL_CA: begin
        mul_a = c_q;
        mul_b = {a_q[31], a_q};
      end
      fte_pkg::OP_MUL_SB: begin
        mul_a = s_q;
        mul_b = {b_q[31], b_q};
      end
      fte_pkg::OP_MUL_MLO: begin
        mul_a = {2'b00, x_mag[15:0]};
        mul_b = {1'b0, position_scale};
      end
      fte_pkg::OP_MUL_MHI: begin
        mul_a = {1'b0, x_mag[32:16]};
        mul_b = {1'b0, position_scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one divider step: eight quotient bits of the division by k
  always_comb begin
    logic [KW:0]   r;
    logic [DW-1:0] d;
    r = '0;
    d = dq;
    rem_next = rem;
    for (int i = 0; i < fte_pkg::DIV_BITS; i++) begin
      r = {rem_next, d[DW-1]};
      d = {d[DW-2:0], 1'b0};
      if (r >= {1'b0, kval}) begin
        r = r - {1'b0, kval};
        d[0] = 1'b1;
      end
      rem_next = r[KW-1:0];
    end
    dq_next = d;
  end

  // main datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      fte_pkg::OP_START: begin
        time_q <= in_data.time_fraction;
      end
      fte_pkg::OP_JOINT_INIT: begin
        acc   <= {phase_mem[jidx], 16'h0000} + {time_q[30:0], 1'b0};
        pos   <= PW'(base_mem[jidx]);
        vel   <= '0;
        caddr <= CAW'(jidx);
      end
      fte_pkg::OP_RD_COS: begin
        s_q <= rom_q;
      end
      fte_pkg::OP_MUL_SA: begin
        c_q <= rom_q;
      end
      fte_pkg::OP_MUL_CB: begin
        t1 <= prod;
      end
      fte_pkg::OP_MUL_CA: begin
        t1 <= t1 - prod;
      end
      fte_pkg::OP_MUL_SB: begin
        x_mag <= round_mag(t1);
        x_neg <= t1[50];
        t2    <= prod;
      end
      fte_pkg::OP_MUL_MLO: begin
        t2 <= t2 + prod;
      end
      fte_pkg::OP_MUL_MHI: begin
        v_mag   <= round_mag(t2);
        v_neg   <= t2[50];
        lo_part <= 32'((prod[47:0] + 48'd32768) >> 16);
      end
      fte_pkg::OP_SCALE: begin
        dq  <= prod[47:0] + DW'(lo_part);
        rem <= '0;
        vel <= v_neg ? (vel - VW'(v_mag)) : (vel + VW'(v_mag));
      end
      fte_pkg::OP_DIV_STEP: begin
        dq  <= dq_next;
        rem <= rem_next;
      end
      fte_pkg::OP_ACCUM: begin
        pos   <= x_neg ? (pos - PW'(dq)) : (pos + PW'(dq));
        acc   <= acc + {time_q[30:0], 1'b0};
        caddr <= caddr + CAW'(JOINTS);
      end
      default: begin
      end
    endcase
  end

  // saturation checks
  assign pos_sat = !((&pos[PW-1:31]) || !(|pos[PW-1:31]));
  assign vel_sat = !((&vel[VW-1:31]) || !(|vel[VW-1:31]));

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.joint_index <= 4'(cmd.joint);
      out_data.position    <= pos_sat ? (pos[PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                      : pos[31:0];
      out_data.velocity    <= vel_sat ? (vel[VW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                      : vel[31:0];
      out_data.saturated   <= pos_sat || vel_sat;
      out_data.last        <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign out_busy = out_valid && out_stall;

endmodule

/* sv/fte_ctrl.sv */
// ---------------------------------------------------------------------------
// fte_ctrl
// Sequencer over joints, harmonics and the steps of one harmonic term.
// ---------------------------------------------------------------------------
module fte_ctrl #(
  parameter int HARMONICS = fte_pkg::HARMONICS_DEF,
  parameter int JOINTS    = fte_pkg::JOINTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       req_type,
  output logic             in_stall,
  input  logic             out_busy,
  output fte_pkg::dp_cmd_t cmd
);

  localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int KW  = $clog2(HARMONICS + 1);
  localparam int DCW = (fte_pkg::DIV_STEPS > 1) ? $clog2(fte_pkg::DIV_STEPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD_SIN,
    S_RD_COS,
    S_MUL_SA,
    S_MUL_CB,
    S_MUL_CA,
    S_MUL_SB,
    S_MUL_MLO,
    S_MUL_MHI,
    S_SCALE,
    S_DIV,
    S_ACCUM,
    S_EMIT
  } state_t;

  state_t         state;
  logic [JW-1:0]  joint;
  logic [KW-1:0]  harm;
  logic [DCW-1:0] div_cnt;
  logic           accept;
  logic           last_joint;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign last_joint = (joint == JW'(JOINTS - 1));

  // command decode
  always_comb begin
    cmd.op    = fte_pkg::OP_NONE;
    cmd.emit  = 1'b0;
    cmd.joint = 5'(joint);
    cmd.harm  = 5'(harm);
    cmd.last  = last_joint;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            fte_pkg::REQ_WRITE_COEF:  cmd.op = fte_pkg::OP_WR_COEF;
            fte_pkg::REQ_WRITE_JOINT: cmd.op = fte_pkg::OP_WR_JOINT;
            fte_pkg::REQ_EVALUATE:    cmd.op = fte_pkg::OP_START;
            default:                  cmd.op = fte_pkg::OP_NONE;
          endcase
        end
      end
      S_INIT:    cmd.op = fte_pkg::OP_JOINT_INIT;
      S_RD_SIN:  cmd.op = fte_pkg::OP_RD_SIN;
      S_RD_COS:  cmd.op = fte_pkg::OP_RD_COS;
      S_MUL_SA:  cmd.op = fte_pkg::OP_MUL_SA;
      S_MUL_CB:  cmd.op = fte_pkg::OP_MUL_CB;
      S_MUL_CA:  cmd.op = fte_pkg::OP_MUL_CA;
      S_MUL_SB:  cmd.op = fte_pkg::OP_MUL_SB;
      S_MUL_MLO: cmd.op = fte_pkg::OP_MUL_MLO;
      S_MUL_MHI: cmd.op = fte_pkg::OP_MUL_MHI;
      S_SCALE:   cmd.op = fte_pkg::OP_SCALE;
      S_DIV:     cmd.op = fte_pkg::OP_DIV_STEP;
      S_ACCUM:   cmd.op = fte_pkg::OP_ACCUM;
      S_EMIT:    cmd.emit = !out_busy;
      default:   cmd.op = fte_pkg::OP_NONE;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      joint   <= '0;
      harm    <= '0;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (req_type == fte_pkg::REQ_EVALUATE)) begin
            joint <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          harm  <= KW'(1);
          state <= S_RD_SIN;
        end
        S_RD_SIN:  state <= S_RD_COS;
        S_RD_COS:  state <= S_MUL_SA;
        S_MUL_SA:  state <= S_MUL_CB;
        S_MUL_CB:  state <= S_MUL_CA;
        S_MUL_CA:  state <= S_MUL_SB;
        S_MUL_SB:  state <= S_MUL_MLO;
        S_MUL_MLO: state <= S_MUL_MHI;
        S_MUL_MHI: state <= S_SCALE;
        S_SCALE: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == DCW'(fte_pkg::DIV_STEPS - 1)) begin
            state <= S_ACCUM;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_ACCUM: begin
          if (harm == KW'(HARMONICS)) begin
            state <= S_EMIT;
          end else begin
            harm  <= harm + 1'b1;
            state <= S_RD_SIN;
          end
        end
        S_EMIT: begin
          if (!out_busy) begin
            if (last_joint) begin
              state <= S_IDLE;
            end else begin
              joint <= joint + 1'b1;
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/fourier_trajectory_evaluator_top.sv */
// ---------------------------------------------------------------------------
// fourier_trajectory_evaluator_top
// Fourier series trajectory evaluator: per joint position and velocity from
// stored harmonic coefficients at a requested fraction of the period.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests. Coefficient and joint offset
//   writes are applied when taken. An evaluate request returns one result per
//   joint on out_valid/out_stall/out_data, in joint order, last set on the
//   final joint.
//   Each harmonic term takes two table reads, six passes of the one 18x33
//   multiplier, a scale step, six divider steps of eight bits and an
//   accumulate step. in_stall is high for the whole evaluation.
//   The output register holds a result until it is taken; while out_stall
//   is high with a result waiting, the sequencer holds before the next one.
//   Reset clears control, sets position_scale to its default and the base
//   positions to zero; coefficients and phases must be written before use.
//   cfg_valid/cfg_ready writes position_scale, always ready; the user must write it while idle (not enforced).
// ---------------------------------------------------------------------------
module fourier_trajectory_evaluator_top #(
  parameter int HARMONICS       = fte_pkg::HARMONICS_DEF,
  parameter int JOINTS          = fte_pkg::JOINTS_DEF,
  parameter int SINE_TABLE_BITS = fte_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fte_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  fte_pkg::dp_cmd_t cmd;
  logic             out_busy;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  fte_ctrl #(
    .HARMONICS(HARMONICS),
    .JOINTS   (JOINTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .req_type(in_data.req_type),
    .in_stall(in_stall),
    .out_busy(out_busy),
    .cmd     (cmd)
  );

  fte_datapath #(
    .HARMONICS      (HARMONICS),
    .JOINTS         (JOINTS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_busy (out_busy)
  );

endmodule

/* verif/fourier_trajectory_evaluator_top_tb.sv */
// ---------------------------------------------------------------------------
// fourier_trajectory_evaluator_top_tb
// Self-checking bench for the Fourier trajectory evaluator. A clocked driver
// feeds requests from a queue, and a clocked monitor compares every result
// with a bit-exact prediction of the position and velocity of each joint.
// Four phases run with different position_scale values and idling patterns.
// ---------------------------------------------------------------------------
module fourier_trajectory_evaluator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NH = fte_pkg::HARMONICS_DEF;
  localparam int NJ = fte_pkg::JOINTS_DEF;
  localparam int TB = fte_pkg::SINE_TABLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 46;

  // request code with no meaning, expected to be ignored
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fte_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fte_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  // bench state
  fte_pkg::in_item_t  pending_requests[$];
  fte_pkg::out_item_t expected_results[$];
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;

  // predictor copy of the block state
  logic [31:0]        scale_q;
  logic signed [31:0] sine_coef[NH*NJ];
  logic signed [31:0] cos_coef[NH*NJ];
  logic [15:0]        joint_phase[NJ];
  logic signed [31:0] joint_base[NJ];

  fourier_trajectory_evaluator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // sine table entry, Q1.16, folded odd series in Q2.30
  function automatic longint table_sine_q16(input int unsigned idx);
    longint unsigned p, u, th, t2, r, s, q;
    logic neg;
    p = (longint'(idx & ((1 << TB) - 1)) << (32 - TB)) & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (p >= 64'h8000_0000) begin
      neg = 1'b1;
      p = p - 64'h8000_0000;
    end
    u = (p > 64'h4000_0000) ? 64'h8000_0000 - p : p;
    th = (u * 64'd6746518852) >> 32;
    t2 = (th * th) >> 30;
    r = 64'd1073741824 - ((t2 * 64'd1073741824) >> 30) / 64'd110;
    r = 64'd1073741824 - ((t2 * r) >> 30) / 64'd72;
    r = 64'd1073741824 - ((t2 * r) >> 30) / 64'd42;
    r = 64'd1073741824 - ((t2 * r) >> 30) / 64'd20;
    r = 64'd1073741824 - ((t2 * r) >> 30) / 64'd6;
    s = (th * r) >> 30;
    q = (s + 64'd8192) >> 14;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Q16.16 rounding, half away from zero
  function automatic longint round_q16(input longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + 64'd32768) >> 16;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // apply one request to the predictor state and queue its results
  task automatic trajectory_predict(input fte_pkg::in_item_t rq);
    longint pos, vel, s, c, x;
    longint unsigned acc, m;
    int unsigned idx;
    fte_pkg::out_item_t res;
    int hi;
    if (rq.req_type == fte_pkg::REQ_WRITE_COEF) begin
      if (rq.joint_sel < NJ) begin
        hi = rq.harmonic_sel * NJ + rq.joint_sel;
        sine_coef[hi] = rq.sine_amplitude;
        cos_coef[hi]  = rq.cosine_amplitude;
      end
    end else if (rq.req_type == fte_pkg::REQ_WRITE_JOINT) begin
      if (rq.joint_sel < NJ) begin
        joint_phase[rq.joint_sel] = rq.phase_offset;
        joint_base[rq.joint_sel]  = rq.base_position;
      end
    end else if (rq.req_type == fte_pkg::REQ_EVALUATE) begin
      for (int j = 0; j < NJ; j++) begin
        pos = joint_base[j];
        vel = 0;
        res = '0;
        for (int k = 1; k <= NH; k++) begin
          hi = (k - 1) * NJ + j;
          acc = (longint'(2 * k) * longint'(rq.time_fraction)
                 + (longint'(joint_phase[j]) << 16)) & 64'hFFFF_FFFF;
          idx = int'(acc >> (32 - TB));
          s = table_sine_q16(idx);
          c = table_sine_q16(idx + (1 << (TB - 2)));
          x = round_q16(s * longint'(sine_coef[hi]) - c * longint'(cos_coef[hi]));
          m = (x < 0) ? -x : x;
          m = ((m * longint'(scale_q) + 64'd32768) >> 16) / longint'(k);
          pos += (x < 0) ? -longint'(m) : longint'(m);
          vel += round_q16(c * longint'(sine_coef[hi]) + s * longint'(cos_coef[hi]));
        end
        res.joint_index = j[3:0];
        if (pos > 64'sd2147483647) begin
          pos = 64'sd2147483647;
          res.saturated = 1'b1;
        end else if (pos < -64'sd2147483648) begin
          pos = -64'sd2147483648;
          res.saturated = 1'b1;
        end
        if (vel > 64'sd2147483647) begin
          vel = 64'sd2147483647;
          res.saturated = 1'b1;
        end else if (vel < -64'sd2147483648) begin
          vel = -64'sd2147483648;
          res.saturated = 1'b1;
        end
        res.position = pos[31:0];
        res.velocity = vel[31:0];
        res.last     = (j == NJ - 1);
        expected_results.push_back(res);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        trajectory_predict(in_data);
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // register write seen by the predictor
  always @(posedge clk) begin
    if (rst) begin
      scale_q = fte_pkg::POS_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_q = cfg_data;
    end
  end

  // result monitor
  always @(posedge clk) begin
    fte_pkg::out_item_t ex;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $realtime, out_data);
        fail_count++;
      end else begin
        ex = expected_results.pop_front();
        if (out_data.joint_index !== ex.joint_index) begin
          $display("%0t joint_index: expected %0d actual %0d", $realtime,
                   ex.joint_index, out_data.joint_index);
          fail_count++;
        end
        if (out_data.position !== ex.position) begin
          $display("%0t position j%0d: expected %0d actual %0d", $realtime,
                   ex.joint_index, ex.position, out_data.position);
          fail_count++;
        end
        if (out_data.velocity !== ex.velocity) begin
          $display("%0t velocity j%0d: expected %0d actual %0d", $realtime,
                   ex.joint_index, ex.velocity, out_data.velocity);
          fail_count++;
        end
        if (out_data.saturated !== ex.saturated) begin
          $display("%0t saturated j%0d: expected %0b actual %0b", $realtime,
                   ex.joint_index, ex.saturated, out_data.saturated);
          fail_count++;
        end
        if (out_data.last !== ex.last) begin
          $display("%0t last j%0d: expected %0b actual %0b", $realtime,
                   ex.joint_index, ex.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // wait until all requests are taken and every result has come
  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic fte_pkg::in_item_t make_request(input logic [1:0] rt, input int js,
                                                     input int hs);
    fte_pkg::in_item_t r;
    r.req_type         = rt;
    r.joint_sel        = js[3:0];
    r.harmonic_sel     = hs[2:0];
    r.sine_amplitude   = $urandom;
    r.cosine_amplitude = $urandom;
    r.phase_offset     = 16'($urandom);
    r.base_position    = $urandom;
    r.time_fraction    = $urandom;
    return r;
  endfunction

  // amplitude or base: full range, modest, or an extreme
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom;
    if (sel < 8) return 32'($signed($urandom_range(0, 2097151)) - 1048576);
    if (sel == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  function automatic fte_pkg::in_item_t random_request();
    fte_pkg::in_item_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12)
      r = make_request(fte_pkg::REQ_EVALUATE, $urandom_range(0, 15), $urandom);
    else if (sel < 15)
      r = make_request(REQ_RESERVED, $urandom_range(0, 15), $urandom);
    else if (sel < 25)
      r = make_request(fte_pkg::REQ_WRITE_JOINT, $urandom_range(0, 15), $urandom);
    else
      r = make_request(fte_pkg::REQ_WRITE_COEF, $urandom_range(0, 15), $urandom);
    if ($urandom_range(0, 7) != 0 && r.joint_sel >= NJ)
      r.joint_sel = 4'($urandom_range(0, NJ - 1));
    r.sine_amplitude   = pick_value();
    r.cosine_amplitude = pick_value();
    r.base_position    = pick_value();
    return r;
  endfunction

  // stimulus
  initial begin
    fte_pkg::in_item_t r;
    logic [31:0] phase_scale[4];
    phase_scale[0] = 32'h0000_0000;
    phase_scale[1] = 32'hFFFF_FFFF;
    phase_scale[2] = fte_pkg::POS_SCALE_RESET;
    phase_scale[3] = $urandom;
    for (int i = 0; i < NH*NJ; i++) begin
      sine_coef[i] = '0;
      cos_coef[i]  = '0;
    end
    for (int j = 0; j < NJ; j++) begin
      joint_phase[j] = '0;
      joint_base[j]  = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // load every coefficient and phase before any evaluation
    for (int h = 0; h < NH; h++)
      for (int j = 0; j < NJ; j++) begin
        r = make_request(fte_pkg::REQ_WRITE_COEF, j, h);
        r.sine_amplitude   = pick_value();
        r.cosine_amplitude = pick_value();
        pending_requests.push_back(r);
      end
    for (int j = 0; j < NJ; j++)
      pending_requests.push_back(make_request(fte_pkg::REQ_WRITE_JOINT, j, 0));

    // directed: time extremes, coefficient and base extremes, ignored requests
    r = make_request(fte_pkg::REQ_EVALUATE, 0, 0);
    r.time_fraction = 32'h0000_0000;
    pending_requests.push_back(r);
    r.time_fraction = 32'hFFFF_FFFF;
    pending_requests.push_back(r);
    r.time_fraction = 32'h4000_0000;
    pending_requests.push_back(r);
    for (int h = 0; h < NH; h++) begin
      r = make_request(fte_pkg::REQ_WRITE_COEF, NJ - 1, h);
      r.sine_amplitude   = 32'h7FFF_FFFF;
      r.cosine_amplitude = 32'h8000_0000;
      pending_requests.push_back(r);
    end
    r = make_request(fte_pkg::REQ_WRITE_JOINT, 0, 0);
    r.phase_offset  = 16'hFFFF;
    r.base_position = 32'h7FFF_FFFF;
    pending_requests.push_back(r);
    r = make_request(fte_pkg::REQ_WRITE_JOINT, 1, 0);
    r.phase_offset  = 16'h0000;
    r.base_position = 32'h8000_0000;
    pending_requests.push_back(r);
    // writes to joints past the end and an unused request code are ignored
    pending_requests.push_back(make_request(fte_pkg::REQ_WRITE_COEF, 12, 7));
    pending_requests.push_back(make_request(fte_pkg::REQ_WRITE_JOINT, 15, 0));
    pending_requests.push_back(make_request(REQ_RESERVED, 0, 0));
    pending_requests.push_back(make_request(fte_pkg::REQ_EVALUATE, 0, 0));
    r = make_request(fte_pkg::REQ_EVALUATE, 0, 0);
    r.time_fraction = 32'h8000_0000;
    pending_requests.push_back(r);

    // random phases with differing scale and idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_scale(phase_scale[ph]);
      in_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 16 : 0;
      out_idle_pct = (ph == 2) ? 78 : (ph == 3) ? 16 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == PHASE_ITEMS / 2) begin
          // sender holds off until the block has answered everything
          wait_drained();
        end
        pending_requests.push_back(random_request());
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
